// File: rtl/lirl_pkg.sv
// Shared types and constants of the line-indexed ring log.
package lirl_pkg;

    localparam logic [2:0] CMD_BEGIN = 3'd0;
    localparam logic [2:0] CMD_BYTE  = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_QUERY = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SIZE   = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ROOM  = 10'b0000000010,
        S_DROP  = 10'b0000000100,
        S_PREV  = 10'b0000001000,
        S_PREVX = 10'b0000010000,
        S_FIX   = 10'b0000100000,
        S_LINE  = 10'b0001000000,
        S_Q1    = 10'b0010000000,
        S_Q2    = 10'b0100000000,
        S_RD    = 10'b1000000000
    } state_t;

endpackage

// File: rtl/lirl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lirl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/line_indexed_ring_log_core.sv
// Top level of the line-indexed ring log: byte ring, line start ring and command sequencer.
//
// The log keeps message bytes in one RAM and the ring of line start offsets in a
// second RAM, both with registered read data. A message byte without a line end and
// a clear finish in idle. A byte that closes a line goes through S_LINE, after S_FIX
// when the line end came as LF then CR, and through S_DROP when the oldest line must
// be dropped to make table space. A begin goes through S_ROOM, S_PREV and, if bytes
// are held, S_PREVX; each old line it drops adds S_DROP and S_ROOM, and clearing an
// empty line table first adds S_ROOM again. A line range query goes through S_Q1 and
// S_Q2, a byte read through S_RD. Each result is registered in an output register,
// and the next item is taken when the sequencer is back in idle and the output
// register is free or being emptied. No clearing pass is needed after reset.
module line_indexed_ring_log_core #(
    parameter int BUF_DEPTH  = 4096,
    parameter int LINE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [7:0]  data_byte,
    input  logic [15:0] msg_length,
    input  logic [7:0]  first_line,
    input  logic [7:0]  last_line,
    input  logic [11:0] byte_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  line_count,
    output logic [12:0] bytes_used,
    output logic [11:0] oldest_offset,
    output logic [11:0] range_start,
    output logic [12:0] range_bytes,
    output logic [7:0]  read_data,
    output logic        line_closed
);

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int CW  = $clog2(BUF_DEPTH + 1);
    localparam int LW  = $clog2(LINE_DEPTH);
    localparam int SW  = (CW > 13) ? CW : 13;
    localparam int LMW = (LW > 8) ? LW : 8;
    localparam int MW  = (CW > 16) ? CW : 16;

    lirl_pkg::state_t state_reg, state_next;

    logic          en_reg, en_next;
    logic [12:0]   bsize_reg, bsize_next;
    logic [7:0]    llimit_reg, llimit_next;
    logic [AW-1:0] oldest_byte_reg, oldest_byte_next;
    logic [AW-1:0] next_byte_reg, next_byte_next;
    logic [CW-1:0] used_reg, used_next;
    logic [LW-1:0] held_reg, held_next;
    logic [LW-1:0] oldest_line_reg, oldest_line_next;
    logic [LW-1:0] next_line_reg, next_line_next;
    logic          seen_cr_reg, seen_cr_next;
    logic          seen_lf_reg, seen_lf_next;
    logic [CW-1:0] left_reg, left_next;
    logic          zero0_reg, zero0_next;
    logic          out_valid_reg, out_valid_next;

    logic [2:0]    cmd_reg;
    logic [15:0]   mlen_reg;
    logic [1:0]    stat_reg, stat_next;
    logic [AW-1:0] fix_addr_reg, fix_addr_next;
    logic [LW-1:0] qidx_reg, qidx_next;
    logic [AW-1:0] rstart_reg, rstart_next;
    logic          offs_ok_reg, offs_ok_next;
    logic [LW-1:0] line_raddr_reg;

    logic [1:0]    status_reg;
    logic [7:0]    line_count_reg;
    logic [12:0]   bytes_used_reg;
    logic [11:0]   oldest_offset_reg;
    logic [11:0]   range_start_reg;
    logic [12:0]   range_bytes_reg;
    logic [7:0]    read_data_reg;
    logic          line_closed_reg;

    logic [SW-1:0]  bsz_w;
    logic [LMW-1:0] lim_w;
    logic [CW-1:0]  ring_s;
    logic [LW-1:0]  lim;
    logic [LW:0]    lim1;
    logic [CW-1:0]  avail;

    logic          byte_we;
    logic [AW-1:0] byte_waddr, byte_raddr;
    logic [7:0]    byte_wdata, byte_rd;
    logic          line_we;
    logic [LW-1:0] line_waddr, line_raddr;
    logic [AW-1:0] line_wdata, line_q, line_rd;

    logic          accept, fin, do_wipe, do_drop, do_close, is_close;
    logic [1:0]    o_status;
    logic [AW-1:0] o_rstart;
    logic [CW-1:0] o_rbytes, drop_len;
    logic [7:0]    o_rdata, b;
    logic          o_closed;
    logic [AW-1:0] pos;
    logic [LMW-1:0] qf, ql, qh, qn, qroom;
    logic [LW:0]   qs1, qs2;

    function automatic logic [CW-1:0] span(input logic [AW-1:0] from,
                                           input logic [AW-1:0] to,
                                           input logic [CW-1:0] s);
        if (to > from)
        begin
            span = CW'(to) - CW'(from);
        end
        else
        begin
            span = s - CW'(from) + CW'(to);
        end
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p,
                                               input logic [CW-1:0] s);
        ring_inc = (CW'(p) >= s - CW'(1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p,
                                               input logic [CW-1:0] s);
        ring_dec = (p == '0) ? AW'(s - CW'(1)) : p - AW'(1);
    endfunction

    function automatic logic [LW-1:0] line_inc(input logic [LW-1:0] x,
                                               input logic [LW-1:0] l);
        line_inc = (x >= l) ? '0 : x + LW'(1);
    endfunction

    lirl_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .raddr (byte_raddr),
        .rdata (byte_rd)
    );

    lirl_ram #(.WIDTH(AW), .DEPTH(LINE_DEPTH)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_q)
    );

    // Entry 0 of the line table reads as zero until written after a wipe.
    assign line_rd = (line_raddr_reg == '0 && zero0_reg) ? '0 : line_q;

    always_comb
    begin
        bsz_w = SW'(bsize_reg);
        if (bsz_w < SW'(2))
        begin
            ring_s = CW'(2);
        end
        else if (bsz_w > SW'(BUF_DEPTH))
        begin
            ring_s = CW'(BUF_DEPTH);
        end
        else
        begin
            ring_s = CW'(bsz_w);
        end
        lim_w = LMW'(llimit_reg);
        if (lim_w < LMW'(1))
        begin
            lim = LW'(1);
        end
        else if (lim_w > LMW'(LINE_DEPTH - 1))
        begin
            lim = LW'(LINE_DEPTH - 1);
        end
        else
        begin
            lim = LW'(lim_w);
        end
        lim1 = (LW + 1)'(lim) + (LW + 1)'(1);
        avail = (used_reg > ring_s) ? '0 : ring_s - used_reg;
    end

    assign in_ready = (state_reg == lirl_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;
    assign b = data_byte;
    assign pos = next_byte_reg;
    assign is_close = (seen_cr_reg && b == lirl_pkg::CH_LF)
                   || (seen_lf_reg && b == lirl_pkg::CH_CR);

    always_comb
    begin
        state_next = state_reg;
        en_next = en_reg;
        bsize_next = bsize_reg;
        llimit_next = llimit_reg;
        oldest_byte_next = oldest_byte_reg;
        next_byte_next = next_byte_reg;
        used_next = used_reg;
        held_next = held_reg;
        oldest_line_next = oldest_line_reg;
        next_line_next = next_line_reg;
        seen_cr_next = seen_cr_reg;
        seen_lf_next = seen_lf_reg;
        left_next = left_reg;
        zero0_next = zero0_reg;
        stat_next = stat_reg;
        fix_addr_next = fix_addr_reg;
        qidx_next = qidx_reg;
        rstart_next = rstart_reg;
        offs_ok_next = offs_ok_reg;
        byte_we = 1'b0;
        byte_waddr = pos;
        byte_wdata = b;
        byte_raddr = ring_dec(next_byte_reg, ring_s);
        line_we = 1'b0;
        line_waddr = next_line_reg;
        line_wdata = next_byte_reg;
        line_raddr = line_inc(oldest_line_reg, lim);
        fin = 1'b0;
        do_wipe = 1'b0;
        do_drop = 1'b0;
        do_close = 1'b0;
        o_status = lirl_pkg::ST_OK;
        o_rstart = '0;
        o_rbytes = '0;
        o_rdata = '0;
        o_closed = 1'b0;
        drop_len = '0;
        qf = LMW'(first_line);
        ql = LMW'(last_line);
        qh = LMW'(held_reg);
        qroom = qh - qf + LMW'(1);
        qn = ql - qf + LMW'(1);
        if (qn > qroom)
        begin
            qn = qroom;
        end
        qs1 = (LW + 1)'(oldest_line_reg) + (LW + 1)'(qf) - (LW + 1)'(1);
        if (qs1 >= lim1)
        begin
            qs1 = qs1 - lim1;
        end
        qs2 = (LW + 1)'(oldest_line_reg) + (LW + 1)'(qf + qn - LMW'(1));
        if (qs2 >= lim1)
        begin
            qs2 = qs2 - lim1;
        end

        unique case (state_reg)
            lirl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((command == lirl_pkg::CMD_BEGIN || command == lirl_pkg::CMD_BYTE)
                        && !en_reg)
                    begin
                        o_status = lirl_pkg::ST_DISABLED;
                        fin = 1'b1;
                    end
                    else if (command == lirl_pkg::CMD_BEGIN)
                    begin
                        state_next = lirl_pkg::S_ROOM;
                    end
                    else if (command == lirl_pkg::CMD_BYTE)
                    begin
                        if (left_reg == '0)
                        begin
                            o_status = lirl_pkg::ST_DROPPED;
                            fin = 1'b1;
                        end
                        else
                        begin
                            byte_we = 1'b1;
                            byte_wdata = (seen_lf_reg && b == lirl_pkg::CH_CR)
                                       ? lirl_pkg::CH_LF : b;
                            next_byte_next = ring_inc(pos, ring_s);
                            left_next = left_reg - CW'(1);
                            fix_addr_next = ring_dec(pos, ring_s);
                            if (is_close)
                            begin
                                state_next = seen_lf_reg ? lirl_pkg::S_FIX : lirl_pkg::S_LINE;
                            end
                            else
                            begin
                                seen_lf_next = (b == lirl_pkg::CH_LF);
                                seen_cr_next = (b == lirl_pkg::CH_CR);
                                if (used_reg < ring_s)
                                begin
                                    used_next = used_reg + CW'(1);
                                end
                                fin = 1'b1;
                            end
                        end
                    end
                    else if (command == lirl_pkg::CMD_CLEAR)
                    begin
                        do_wipe = 1'b1;
                        seen_cr_next = 1'b0;
                        seen_lf_next = 1'b0;
                        left_next = '0;
                        fin = 1'b1;
                    end
                    else if (command == lirl_pkg::CMD_QUERY)
                    begin
                        if (qf >= LMW'(1) && qf <= qh && ql >= qf)
                        begin
                            line_raddr = LW'(qs1);
                            qidx_next = LW'(qs2);
                            state_next = lirl_pkg::S_Q1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    else if (command == lirl_pkg::CMD_READ)
                    begin
                        byte_raddr = AW'(byte_offset);
                        offs_ok_next = (32'(byte_offset) < BUF_DEPTH);
                        state_next = lirl_pkg::S_RD;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            lirl_pkg::S_ROOM:
            begin
                if (MW'(mlen_reg) > MW'(avail))
                begin
                    if (MW'(mlen_reg) > MW'(ring_s))
                    begin
                        do_wipe = 1'b1;
                        state_next = lirl_pkg::S_PREV;
                    end
                    else if (held_reg == '0)
                    begin
                        do_wipe = 1'b1;
                    end
                    else
                    begin
                        state_next = lirl_pkg::S_DROP;
                    end
                end
                else
                begin
                    state_next = lirl_pkg::S_PREV;
                end
            end
            lirl_pkg::S_DROP:
            begin
                do_drop = 1'b1;
                if (cmd_reg == lirl_pkg::CMD_BEGIN)
                begin
                    state_next = lirl_pkg::S_ROOM;
                end
                else
                begin
                    do_close = 1'b1;
                end
            end
            lirl_pkg::S_PREV:
            begin
                if (MW'(mlen_reg) > MW'(avail))
                begin
                    left_next = avail;
                    stat_next = lirl_pkg::ST_TRUNC;
                end
                else
                begin
                    left_next = CW'(mlen_reg);
                    stat_next = lirl_pkg::ST_OK;
                end
                seen_cr_next = 1'b0;
                seen_lf_next = 1'b0;
                if (used_reg != '0)
                begin
                    state_next = lirl_pkg::S_PREVX;
                end
                else
                begin
                    o_status = stat_next;
                    fin = 1'b1;
                end
            end
            lirl_pkg::S_PREVX:
            begin
                if (byte_rd == lirl_pkg::CH_CR)
                begin
                    seen_cr_next = 1'b1;
                end
                else if (byte_rd == lirl_pkg::CH_LF)
                begin
                    seen_lf_next = 1'b1;
                end
                o_status = stat_reg;
                fin = 1'b1;
            end
            lirl_pkg::S_FIX:
            begin
                byte_we = 1'b1;
                byte_waddr = fix_addr_reg;
                byte_wdata = lirl_pkg::CH_CR;
                state_next = lirl_pkg::S_LINE;
            end
            lirl_pkg::S_LINE:
            begin
                if (held_reg >= lim)
                begin
                    state_next = lirl_pkg::S_DROP;
                end
                else
                begin
                    do_close = 1'b1;
                end
            end
            lirl_pkg::S_Q1:
            begin
                rstart_next = line_rd;
                line_raddr = qidx_reg;
                state_next = lirl_pkg::S_Q2;
            end
            lirl_pkg::S_Q2:
            begin
                o_rstart = rstart_reg;
                o_rbytes = span(rstart_reg, line_rd, ring_s);
                fin = 1'b1;
            end
            lirl_pkg::S_RD:
            begin
                o_rdata = offs_ok_reg ? byte_rd : '0;
                fin = 1'b1;
            end
            default:
            begin
                state_next = lirl_pkg::S_IDLE;
            end
        endcase

        if (do_drop)
        begin
            drop_len = span(oldest_byte_reg, line_rd, ring_s);
            used_next = (drop_len > used_reg) ? '0 : used_reg - drop_len;
            held_next = held_reg - LW'(1);
            oldest_line_next = line_inc(oldest_line_reg, lim);
            oldest_byte_next = line_rd;
        end

        if (do_close)
        begin
            line_we = 1'b1;
            line_waddr = next_line_next;
            line_wdata = next_byte_next;
            if (next_line_next == '0)
            begin
                zero0_next = 1'b0;
            end
            held_next = held_next + LW'(1);
            next_line_next = line_inc(next_line_next, lim);
            if (used_next < ring_s)
            begin
                used_next = used_next + CW'(1);
            end
            seen_cr_next = 1'b0;
            seen_lf_next = 1'b0;
            o_closed = 1'b1;
            fin = 1'b1;
        end

        if (cfg_write && state_reg == lirl_pkg::S_IDLE)
        begin
            unique case (cfg_index)
                lirl_pkg::CFG_ENABLE:
                begin
                    en_next = cfg_data[0];
                end
                lirl_pkg::CFG_SIZE:
                begin
                    bsize_next = cfg_data;
                    do_wipe = 1'b1;
                end
                lirl_pkg::CFG_LIMIT:
                begin
                    llimit_next = cfg_data[7:0];
                    do_wipe = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (cfg_index == lirl_pkg::CFG_SIZE || cfg_index == lirl_pkg::CFG_LIMIT)
            begin
                seen_cr_next = 1'b0;
                seen_lf_next = 1'b0;
                left_next = '0;
            end
        end

        if (do_wipe)
        begin
            used_next = '0;
            oldest_byte_next = '0;
            next_byte_next = '0;
            held_next = '0;
            oldest_line_next = '0;
            next_line_next = LW'(1);
            zero0_next = 1'b1;
        end

        if (fin)
        begin
            state_next = lirl_pkg::S_IDLE;
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (fin)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lirl_pkg::S_IDLE;
            en_reg <= 1'b1;
            bsize_reg <= 13'd4096;
            llimit_reg <= 8'd255;
            oldest_byte_reg <= '0;
            next_byte_reg <= '0;
            used_reg <= '0;
            held_reg <= '0;
            oldest_line_reg <= '0;
            next_line_reg <= LW'(1);
            seen_cr_reg <= 1'b0;
            seen_lf_reg <= 1'b0;
            left_reg <= '0;
            zero0_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            en_reg <= en_next;
            bsize_reg <= bsize_next;
            llimit_reg <= llimit_next;
            oldest_byte_reg <= oldest_byte_next;
            next_byte_reg <= next_byte_next;
            used_reg <= used_next;
            held_reg <= held_next;
            oldest_line_reg <= oldest_line_next;
            next_line_reg <= next_line_next;
            seen_cr_reg <= seen_cr_next;
            seen_lf_reg <= seen_lf_next;
            left_reg <= left_next;
            zero0_reg <= zero0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            mlen_reg <= msg_length;
        end
        stat_reg <= stat_next;
        fix_addr_reg <= fix_addr_next;
        qidx_reg <= qidx_next;
        rstart_reg <= rstart_next;
        offs_ok_reg <= offs_ok_next;
        line_raddr_reg <= line_raddr;
        if (fin)
        begin
            status_reg <= o_status;
            line_count_reg <= 8'(held_next);
            bytes_used_reg <= 13'(used_next);
            oldest_offset_reg <= 12'(oldest_byte_next);
            range_start_reg <= 12'(o_rstart);
            range_bytes_reg <= 13'(o_rbytes);
            read_data_reg <= o_rdata;
            line_closed_reg <= o_closed;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign line_count = line_count_reg;
    assign bytes_used = bytes_used_reg;
    assign oldest_offset = oldest_offset_reg;
    assign range_start = range_start_reg;
    assign range_bytes = range_bytes_reg;
    assign read_data = read_data_reg;
    assign line_closed = line_closed_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= lim)
        else $error("Held line count exceeds the line limit.");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= ring_s)
        else $error("Used byte count exceeds the ring size.");

    a_next_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_line_reg <= lim && oldest_line_reg <= lim)
        else $error("Line table index beyond the line ring.");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fin && state_reg != lirl_pkg::S_IDLE |-> !out_valid_reg)
        else $error("Result finished while the output register is still full.");
`endif

endmodule
